// ===== rtl/lpsm_pkg.sv =====
// Shared types, register map and constants of the link power state manager.
package lpsm_pkg;

  // Default values of the top-level parameters.
  localparam int unsigned AdcBitsDef  = 12;
  localparam int unsigned TimeBitsDef = 32;

  // Configuration port geometry: seven 32-bit registers at 4-byte spacing.
  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned RegIdxW  = 3;

  // Field widths fixed by the register and result definitions.
  localparam int unsigned ThreshW    = 16;
  localparam int unsigned MsW        = 32;
  localparam int unsigned ZeroCodeW  = 12;
  localparam int unsigned ScaleW     = 24;
  localparam int unsigned AccelW     = 16;
  localparam int unsigned KindW      = 2;
  localparam int unsigned DevStateW  = 2;
  localparam int unsigned PercentW   = 7;
  localparam int unsigned OutDataW   = 16;
  localparam int unsigned FracBits   = 16;

  localparam logic [PercentW-1:0] PercentMax = PercentW'(100);
  localparam logic [FracBits-1:0] RoundHalf  = FracBits'(16'h8000);

  // Register indexes.
  localparam logic [RegIdxW-1:0] RegMotionThreshold = 3'd0;
  localparam logic [RegIdxW-1:0] RegMotionTimeout   = 3'd1;
  localparam logic [RegIdxW-1:0] RegReconnectWindow = 3'd2;
  localparam logic [RegIdxW-1:0] RegSleepTimeout    = 3'd3;
  localparam logic [RegIdxW-1:0] RegReportInterval  = 3'd4;
  localparam logic [RegIdxW-1:0] RegBatteryZeroCode = 3'd5;
  localparam logic [RegIdxW-1:0] RegBatteryScale    = 3'd6;

  // Register reset values.
  localparam logic [ThreshW-1:0]   ResetMotionThreshold = ThreshW'(1100);
  localparam logic [MsW-1:0]       ResetMotionTimeout   = MsW'(30000);
  localparam logic [MsW-1:0]       ResetReconnectWindow = MsW'(5000);
  localparam logic [MsW-1:0]       ResetSleepTimeout    = MsW'(300000);
  localparam logic [MsW-1:0]       ResetReportInterval  = MsW'(60000);
  localparam logic [ZeroCodeW-1:0] ResetBatteryZeroCode = ZeroCodeW'(0);
  localparam logic [ScaleW-1:0]    ResetBatteryScale    = ScaleW'(1600);

  // Kind of an input item.
  typedef enum logic [KindW-1:0] {
    KIND_EVALUATE   = 2'd0,
    KIND_CONNECT    = 2'd1,
    KIND_DISCONNECT = 2'd2,
    KIND_UNUSED     = 2'd3
  } kind_e;

  // Reported device state.
  typedef enum logic [DevStateW-1:0] {
    DEV_ADVERTISING = 2'd0,
    DEV_CONNECTED   = 2'd1,
    DEV_SLEEP       = 2'd2
  } dev_state_e;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [ThreshW-1:0]   motion_threshold;
    logic [MsW-1:0]       motion_idle_ms;
    logic [MsW-1:0]       reconnect_window_ms;
    logic [MsW-1:0]       sleep_after_ms;
    logic [MsW-1:0]       report_interval_ms;
    logic [ZeroCodeW-1:0] battery_zero_code;
    logic [ScaleW-1:0]    battery_scale_q16;
  } cfg_t;

endpackage

// ===== rtl/link_power_state_manager.sv =====
// Top level of the link power state manager: input stage, decision logic, result stage.
//
// The block takes one item per clock cycle on its input stream, unless an evaluate item in the
// input register waits for a full result register, and gives one result item per evaluate
// item: once the result register is free, the link, motion and report decisions, the state
// update and the battery percent (one 12x24 multiply with rounding and clamping) are formed
// and written to the result register. Connect, disconnect and the unused kind update state
// (or nothing) and give no result. The state update is registered as the item is processed,
// so an item may follow in the very next cycle and sees the effect of the one before. Input
// and result stages are both registered; the input side keeps taking items while a result waits,
// until an evaluate item waits behind it. The user must write configuration registers through
// the APB-style port only while no item is in flight; the block itself does not enforce this.
module link_power_state_manager
  import lpsm_pkg::*;
#(
  parameter int unsigned ADC_BITS  = AdcBitsDef,
  parameter int unsigned TIME_BITS = TimeBitsDef,
  localparam int unsigned InDataW  = ((TIME_BITS + AccelW + ADC_BITS + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata fields from bit 0: now_ms, accel_magnitude, adc_code, zero padding
  input  logic [InDataW-1:0]  s_axis_tdata,
  // tuser fields from bit 0: kind
  input  logic [KindW-1:0]    s_axis_tuser,
  // Result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata fields from bit 0: device_state, ranging_active, battery_report,
  // battery_percent, zero padding
  output logic [OutDataW-1:0] m_axis_tdata,
  // Configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned CmpW  = (TIME_BITS > MsW) ? TIME_BITS : MsW;
  localparam int unsigned MagW  = (ADC_BITS > ZeroCodeW) ? ADC_BITS : ZeroCodeW;
  localparam int unsigned ProdW = MagW + ScaleW + 1;
  localparam int unsigned QW    = ProdW - FracBits;
  localparam int unsigned PadW  = OutDataW - DevStateW - 2 - PercentW;

  cfg_t cfg;

  lpsm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input register.
  logic                 in_valid_q;
  kind_e                in_kind_q;
  logic [TIME_BITS-1:0] in_now_q;
  logic [AccelW-1:0]    in_accel_q;
  logic [ADC_BITS-1:0]  in_adc_q;

  // Link and timing state.
  logic                 link_up_q, link_up_d;
  logic                 disc_pending_q, disc_pending_d;
  logic [TIME_BITS-1:0] disc_time_q, disc_time_d;
  logic [TIME_BITS-1:0] adv_start_q, adv_start_d;
  logic [TIME_BITS-1:0] last_motion_q, last_motion_d;
  logic [TIME_BITS-1:0] last_report_q, last_report_d;

  // Result register.
  logic                 out_valid_q;
  logic [OutDataW-1:0]  out_data_q;

  logic is_eval;
  logic out_free;
  logic proc_fire;
  logic in_fire;

  assign is_eval   = (in_kind_q == KIND_EVALUATE);
  assign out_free  = !out_valid_q || m_axis_tready;
  assign proc_fire = in_valid_q && (!is_eval || out_free);
  assign s_axis_tready = !in_valid_q || proc_fire;
  assign in_fire   = s_axis_tvalid && s_axis_tready;

  // Input stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Input stage payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_kind_q  <= kind_e'(s_axis_tuser);
      in_now_q   <= s_axis_tdata[TIME_BITS-1:0];
      in_accel_q <= s_axis_tdata[TIME_BITS +: AccelW];
      in_adc_q   <= s_axis_tdata[TIME_BITS + AccelW +: ADC_BITS];
    end
  end

  // Time differences, taken modulo the timestamp width.
  logic [TIME_BITS-1:0] el_disc;
  logic [TIME_BITS-1:0] el_adv;
  logic [TIME_BITS-1:0] el_motion;
  logic [TIME_BITS-1:0] el_report;
  logic [TIME_BITS-1:0] adv_ref;
  logic [TIME_BITS-1:0] motion_ref;
  logic                 in_grace;
  logic                 grace_over;
  logic                 motion_seen;
  logic                 report_due;
  logic                 ranging_active;
  dev_state_e           dev_state;

  // Link decision: connected, grace window after a disconnect, then advertising or sleep.
  always_comb begin
    el_disc    = in_now_q - disc_time_q;
    in_grace   = disc_pending_q &&
                 (CmpW'(el_disc) <= CmpW'(cfg.reconnect_window_ms));
    grace_over = !link_up_q && disc_pending_q && !in_grace;
    adv_ref    = grace_over ? in_now_q : adv_start_q;
    el_adv     = in_now_q - adv_ref;
    if (link_up_q || in_grace) begin
      dev_state = DEV_CONNECTED;
    end else if (CmpW'(el_adv) >= CmpW'(cfg.sleep_after_ms)) begin
      dev_state = DEV_SLEEP;
    end else begin
      dev_state = DEV_ADVERTISING;
    end
  end

  // Motion timeout and battery report interval.
  always_comb begin
    motion_seen    = in_accel_q > cfg.motion_threshold;
    motion_ref     = motion_seen ? in_now_q : last_motion_q;
    el_motion      = in_now_q - motion_ref;
    ranging_active = CmpW'(el_motion) < CmpW'(cfg.motion_idle_ms);
    el_report      = in_now_q - last_report_q;
    report_due     = CmpW'(el_report) >= CmpW'(cfg.report_interval_ms);
  end

  // Battery percent: (code - zero code) times the Q8.16 scale, rounded half up, clamped.
  logic [MagW-1:0]     code_ext;
  logic [MagW-1:0]     zero_ext;
  logic [MagW-1:0]     mag;
  logic [ProdW-1:0]    prod;
  logic [QW-1:0]       pct_q;
  logic [PercentW-1:0] percent;

  always_comb begin
    code_ext = MagW'(in_adc_q);
    zero_ext = MagW'(cfg.battery_zero_code);
    mag      = (code_ext > zero_ext) ? (code_ext - zero_ext) : '0;
    prod     = ProdW'(mag) * ProdW'(cfg.battery_scale_q16) + ProdW'(RoundHalf);
    pct_q    = prod[ProdW-1:FracBits];
    percent  = (pct_q > QW'(PercentMax)) ? PercentMax : pct_q[PercentW-1:0];
  end

  // Next state for the item being processed.
  always_comb begin
    link_up_d      = link_up_q;
    disc_pending_d = disc_pending_q;
    disc_time_d    = disc_time_q;
    adv_start_d    = adv_start_q;
    last_motion_d  = last_motion_q;
    last_report_d  = last_report_q;
    if (proc_fire) begin
      case (in_kind_q)
        KIND_CONNECT: begin
          link_up_d      = 1'b1;
          disc_pending_d = 1'b0;
        end
        KIND_DISCONNECT: begin
          link_up_d      = 1'b0;
          disc_pending_d = 1'b1;
          disc_time_d    = in_now_q;
        end
        KIND_EVALUATE: begin
          if (grace_over) begin
            disc_pending_d = 1'b0;
            adv_start_d    = in_now_q;
          end
          last_motion_d = motion_ref;
          if (report_due) begin
            last_report_d = in_now_q;
          end
        end
        default: ;
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_up_q      <= 1'b0;
      disc_pending_q <= 1'b0;
      disc_time_q    <= '0;
      adv_start_q    <= '0;
      last_motion_q  <= '0;
      last_report_q  <= '0;
    end else begin
      link_up_q      <= link_up_d;
      disc_pending_q <= disc_pending_d;
      disc_time_q    <= disc_time_d;
      adv_start_q    <= adv_start_d;
      last_motion_q  <= last_motion_d;
      last_report_q  <= last_report_d;
    end
  end

  // Result stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_fire && is_eval) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result stage payload.
  always_ff @(posedge clk_i) begin
    if (proc_fire && is_eval) begin
      out_data_q <= {PadW'(0), percent, report_due, ranging_active, dev_state};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // A held input item is never overwritten by a new one.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !proc_fire) |-> !s_axis_tready)
    else $error("input register overwritten while its item is still pending");

  // Linked and disconnect-pending never hold together.
  a_link_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(link_up_q && disc_pending_q))
    else $error("link up with a disconnect still pending");

  // A report pulse restarts the interval at the item's timestamp.
  a_report_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_fire && is_eval && report_due) |=> (last_report_q == $past(in_now_q)))
    else $error("report interval not restarted after a pulse");

  // A delivered percent never exceeds full charge.
  a_percent_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q[DevStateW + 2 +: PercentW] <= PercentMax))
    else $error("battery percent above 100");

endmodule

// ===== rtl/lpsm_regs.sv =====
// Configuration register file with its APB-style access port.
module lpsm_regs
  import lpsm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t               cfg_q;
  logic               wr_en;
  logic [RegIdxW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[CfgAddrW-1:2];
  assign cfg_o   = cfg_q;

  // Register writes; an index beyond the map is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.motion_threshold    <= ResetMotionThreshold;
      cfg_q.motion_idle_ms      <= ResetMotionTimeout;
      cfg_q.reconnect_window_ms <= ResetReconnectWindow;
      cfg_q.sleep_after_ms      <= ResetSleepTimeout;
      cfg_q.report_interval_ms  <= ResetReportInterval;
      cfg_q.battery_zero_code   <= ResetBatteryZeroCode;
      cfg_q.battery_scale_q16   <= ResetBatteryScale;
    end else if (wr_en) begin
      case (reg_idx)
        RegMotionThreshold: cfg_q.motion_threshold    <= pwdata[ThreshW-1:0];
        RegMotionTimeout:   cfg_q.motion_idle_ms      <= pwdata[MsW-1:0];
        RegReconnectWindow: cfg_q.reconnect_window_ms <= pwdata[MsW-1:0];
        RegSleepTimeout:    cfg_q.sleep_after_ms      <= pwdata[MsW-1:0];
        RegReportInterval:  cfg_q.report_interval_ms  <= pwdata[MsW-1:0];
        RegBatteryZeroCode: cfg_q.battery_zero_code   <= pwdata[ZeroCodeW-1:0];
        RegBatteryScale:    cfg_q.battery_scale_q16   <= pwdata[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    case (reg_idx)
      RegMotionThreshold: prdata = CfgDataW'(cfg_q.motion_threshold);
      RegMotionTimeout:   prdata = CfgDataW'(cfg_q.motion_idle_ms);
      RegReconnectWindow: prdata = CfgDataW'(cfg_q.reconnect_window_ms);
      RegSleepTimeout:    prdata = CfgDataW'(cfg_q.sleep_after_ms);
      RegReportInterval:  prdata = CfgDataW'(cfg_q.report_interval_ms);
      RegBatteryZeroCode: prdata = CfgDataW'(cfg_q.battery_zero_code);
      RegBatteryScale:    prdata = CfgDataW'(cfg_q.battery_scale_q16);
      default:            prdata = '0;
    endcase
  end

endmodule

// ===== test/link_power_state_manager_tb.sv =====
// Self-checking testbench of the link power state manager: stream and register traffic.
module link_power_state_manager_tb;
  import lpsm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned InDataW       = ((TimeBitsDef + AccelW + AdcBitsDef + 7) / 8) * 8;
  localparam int unsigned AdcW          = AdcBitsDef;
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned SettleCycles  = 8;
  localparam logic [RegIdxW-1:0] RegUnmapped = 3'd7;

  // One expected decision item.
  typedef struct {
    dev_state_e          state;
    logic                ranging;
    logic                pulse;
    logic [PercentW-1:0] percent;
  } decision_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [KindW-1:0]    s_axis_tuser  = KIND_EVALUATE;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [CfgAddrW-1:0] paddr         = '0;
  logic [CfgDataW-1:0] pwdata        = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  // Predicted configuration and link state.
  cfg_t           cfg_model;
  logic           link_up_m;
  logic           pending_m;
  logic [MsW-1:0] disc_time_m;
  logic [MsW-1:0] adv_start_m;
  logic [MsW-1:0] motion_time_m;
  logic [MsW-1:0] report_time_m;

  decision_t      expected_decisions[$];
  decision_t      oldest;
  logic [MsW-1:0] clock_ms      = '0;
  int             errors        = 0;
  int             stall_left    = 0;
  int unsigned    idle_cycles   = 0;
  bit             tx_gaps_on    = 1'b1;
  bit             rx_stalls_on  = 1'b1;

  link_power_state_manager i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Time since a mark, modulo the timestamp width.
  function automatic logic [MsW-1:0] elapsed_ms(logic [MsW-1:0] now, logic [MsW-1:0] mark);
    elapsed_ms = now - mark;
  endfunction

  // Rounded and clamped charge percent for one ADC code.
  function automatic logic [PercentW-1:0] charge_percent(logic [AdcW-1:0] code);
    logic signed [AdcW+1:0] diff;
    logic [39:0]            q;
    diff = $signed({2'b00, code}) - $signed({2'b00, cfg_model.battery_zero_code});
    if (diff <= 0) return '0;
    q = (40'(diff[AdcW-1:0]) * 40'(cfg_model.battery_scale_q16) + 40'(RoundHalf)) >> FracBits;
    if (q > 40'(PercentMax)) return PercentMax;
    return q[PercentW-1:0];
  endfunction

  // Register contents as a read should return them.
  function automatic logic [CfgDataW-1:0] register_value(logic [RegIdxW-1:0] idx);
    case (idx)
      RegMotionThreshold: return CfgDataW'(cfg_model.motion_threshold);
      RegMotionTimeout:   return CfgDataW'(cfg_model.motion_idle_ms);
      RegReconnectWindow: return CfgDataW'(cfg_model.reconnect_window_ms);
      RegSleepTimeout:    return CfgDataW'(cfg_model.sleep_after_ms);
      RegReportInterval:  return CfgDataW'(cfg_model.report_interval_ms);
      RegBatteryZeroCode: return CfgDataW'(cfg_model.battery_zero_code);
      RegBatteryScale:    return CfgDataW'(cfg_model.battery_scale_q16);
      default:            return '0;
    endcase
  endfunction

  // Random idle length: mostly short, now and then long.
  function automatic int gap_length();
    int r;
    r = $urandom_range(99);
    if (r < 65) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  task automatic reset_model();
    cfg_model.motion_threshold    = ResetMotionThreshold;
    cfg_model.motion_idle_ms      = ResetMotionTimeout;
    cfg_model.reconnect_window_ms = ResetReconnectWindow;
    cfg_model.sleep_after_ms      = ResetSleepTimeout;
    cfg_model.report_interval_ms  = ResetReportInterval;
    cfg_model.battery_zero_code   = ResetBatteryZeroCode;
    cfg_model.battery_scale_q16   = ResetBatteryScale;
    link_up_m     = 1'b0;
    pending_m     = 1'b0;
    disc_time_m   = '0;
    adv_start_m   = '0;
    motion_time_m = '0;
    report_time_m = '0;
  endtask

  task automatic apply_register(logic [RegIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    case (idx)
      RegMotionThreshold: cfg_model.motion_threshold    = value[ThreshW-1:0];
      RegMotionTimeout:   cfg_model.motion_idle_ms      = value[MsW-1:0];
      RegReconnectWindow: cfg_model.reconnect_window_ms = value[MsW-1:0];
      RegSleepTimeout:    cfg_model.sleep_after_ms      = value[MsW-1:0];
      RegReportInterval:  cfg_model.report_interval_ms  = value[MsW-1:0];
      RegBatteryZeroCode: cfg_model.battery_zero_code   = value[ZeroCodeW-1:0];
      RegBatteryScale:    cfg_model.battery_scale_q16   = value[ScaleW-1:0];
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(string what, logic [31:0] expv, logic [31:0] actv);
    errors++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, expv, actv);
  endtask

  // Update the link model with one accepted item and queue its decision, if any.
  task automatic predict_decision(kind_e k, logic [MsW-1:0] now, logic [AccelW-1:0] accel,
                                  logic [AdcW-1:0] adc);
    decision_t d;
    logic      advertising;
    case (k)
      KIND_CONNECT: begin
        link_up_m = 1'b1;
        pending_m = 1'b0;
      end
      KIND_DISCONNECT: begin
        link_up_m   = 1'b0;
        pending_m   = 1'b1;
        disc_time_m = now;
      end
      KIND_EVALUATE: begin
        advertising = 1'b0;
        d.state     = DEV_CONNECTED;
        if (!link_up_m) begin
          advertising = 1'b1;
          // Grace window after a disconnect still counts as connected.
          if (pending_m) begin
            if (elapsed_ms(now, disc_time_m) <= cfg_model.reconnect_window_ms) begin
              advertising = 1'b0;
            end else begin
              pending_m   = 1'b0;
              adv_start_m = now;
            end
          end
          if (advertising)
            d.state = (elapsed_ms(now, adv_start_m) >= cfg_model.sleep_after_ms) ?
                      DEV_SLEEP : DEV_ADVERTISING;
        end
        if (accel > cfg_model.motion_threshold) motion_time_m = now;
        d.ranging = (elapsed_ms(now, motion_time_m) >= cfg_model.motion_idle_ms) ? 1'b0 : 1'b1;
        d.pulse = 1'b0;
        if (elapsed_ms(now, report_time_m) >= cfg_model.report_interval_ms) begin
          report_time_m = now;
          d.pulse       = 1'b1;
        end
        d.percent = charge_percent(adc);
        expected_decisions.push_back(d);
      end
      default: ;
    endcase
  endtask

  // Offer one item, wait for its acceptance and predict its effect.
  task automatic send_item(kind_e k, logic [MsW-1:0] now, logic [AccelW-1:0] accel,
                           logic [AdcW-1:0] adc);
    int gap;
    gap = 0;
    if (tx_gaps_on && $urandom_range(99) < 40) gap = gap_length();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= k;
    s_axis_tdata  <= InDataW'({adc, accel, now});
    do @(posedge clk_i); while (!s_axis_tready);
    predict_decision(k, now, accel, adc);
  endtask

  // Stop sending, wait for every queued decision and let the pipeline settle.
  task automatic drain_decisions();
    s_axis_tvalid <= 1'b0;
    while (expected_decisions.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Register write followed by a read back of the same address.
  task automatic write_register(logic [RegIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    apply_register(idx, value);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (idx != RegUnmapped && prdata !== register_value(idx))
      flag_mismatch($sformatf("register %0d read back", idx), register_value(idx), prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all_registers(logic [CfgDataW-1:0] value);
    for (int i = 0; i <= int'(RegBatteryScale); i++) write_register(RegIdxW'(i), value);
  endtask

  task automatic restore_defaults();
    write_register(RegMotionThreshold, CfgDataW'(ResetMotionThreshold));
    write_register(RegMotionTimeout,   CfgDataW'(ResetMotionTimeout));
    write_register(RegReconnectWindow, CfgDataW'(ResetReconnectWindow));
    write_register(RegSleepTimeout,    CfgDataW'(ResetSleepTimeout));
    write_register(RegReportInterval,  CfgDataW'(ResetReportInterval));
    write_register(RegBatteryZeroCode, CfgDataW'(ResetBatteryZeroCode));
    write_register(RegBatteryScale,    CfgDataW'(ResetBatteryScale));
  endtask

  // Random settings: zero, all ones, small values that the time steps can reach, 0x10000, or anything.
  task automatic randomise_registers();
    int          r;
    logic [31:0] value;
    for (int i = 0; i <= int'(RegBatteryScale); i++) begin
      r = $urandom_range(99);
      if (r < 10)      value = '0;
      else if (r < 20) value = '1;
      else if (r < 70) value = $urandom_range(20000);
      else if (r < 75) value = 32'h0001_0000;
      else             value = $urandom;
      write_register(RegIdxW'(i), value);
    end
  endtask

  // Reset state, link events, the grace window edges and timestamp wrap.
  task automatic test_link_events();
    send_item(KIND_EVALUATE,   32'd0, 16'h0000, 12'h000);
    send_item(KIND_EVALUATE,   32'hFFFF_FFFF, 16'hFFFF, 12'hFFF);
    send_item(KIND_UNUSED,     32'd5, 16'hFFFF, 12'hFFF);
    send_item(KIND_CONNECT,    32'd10, 16'h0000, 12'h000);
    send_item(KIND_EVALUATE,   32'd20, 16'd1100, 12'd2048);
    send_item(KIND_DISCONNECT, 32'd1000, 16'h0000, 12'h000);
    send_item(KIND_EVALUATE,   32'd6000, 16'd1101, 12'd100);
    send_item(KIND_EVALUATE,   32'd6001, 16'h0000, 12'd100);
    send_item(KIND_DISCONNECT, 32'hFFFF_FF00, 16'h0000, 12'h000);
    send_item(KIND_EVALUATE,   32'h0000_0100, 16'h5555, 12'hAAA);
    send_item(KIND_CONNECT,    32'h0000_0200, 16'h0000, 12'h000);
    send_item(KIND_DISCONNECT, 32'h0000_0300, 16'h0000, 12'h000);
    send_item(KIND_CONNECT,    32'h0000_0400, 16'h0000, 12'h000);
    send_item(KIND_EVALUATE,   32'h0001_0000, 16'hAAAA, 12'h555);
    drain_decisions();
  endtask

  // Every register at zero, then at all ones, with an unmapped write in between.
  task automatic test_register_extremes();
    write_all_registers('0);
    write_register(RegUnmapped, $urandom);
    send_item(KIND_DISCONNECT, 32'd50, 16'h0000, 12'h000);
    send_item(KIND_EVALUATE,   32'd50, 16'h0000, 12'hFFF);
    send_item(KIND_EVALUATE,   32'd51, 16'h0001, 12'h001);
    drain_decisions();
    write_all_registers('1);
    send_item(KIND_EVALUATE, 32'h8000_0000, 16'hFFFF, 12'hFFF);
    send_item(KIND_EVALUATE, 32'h7FFF_FFFF, 16'hFFFE, 12'hFFE);
    drain_decisions();
  endtask

  // Codes around the zero code, the upper limit of 100 percent and round half up.
  task automatic test_battery_percent();
    write_register(RegBatteryZeroCode, 32'd2000);
    write_register(RegBatteryScale,    32'h0001_0000);
    send_item(KIND_EVALUATE, 32'd100, 16'd0, 12'd1999);
    send_item(KIND_EVALUATE, 32'd101, 16'd0, 12'd2000);
    send_item(KIND_EVALUATE, 32'd102, 16'd0, 12'd2001);
    send_item(KIND_EVALUATE, 32'd103, 16'd0, 12'd2100);
    drain_decisions();
    write_register(RegBatteryScale, 32'h0000_8000);
    send_item(KIND_EVALUATE, 32'd104, 16'd0, 12'd2001);
    drain_decisions();
  endtask

  // Random traffic: timestamps mostly step forward, a share lands on a timeout edge.
  task automatic run_traffic(int count, int pause_every);
    int             sent;
    int             r;
    int             v;
    kind_e          k;
    logic [MsW-1:0] now;
    logic [MsW-1:0] step;
    logic [AccelW-1:0] accel;
    logic [AdcW-1:0]   adc;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(99);
      if (r < 68)      k = KIND_EVALUATE;
      else if (r < 80) k = KIND_CONNECT;
      else if (r < 95) k = KIND_DISCONNECT;
      else             k = KIND_UNUSED;

      // Timestamp: on or beside a timeout edge, anywhere, or a step on from the last one.
      r    = $urandom_range(99);
      step = 32'($urandom_range(2)) - 32'd1;
      case ($urandom_range(3))
        0: now = disc_time_m + cfg_model.reconnect_window_ms + step;
        1: now = adv_start_m + cfg_model.sleep_after_ms + step;
        2: now = motion_time_m + cfg_model.motion_idle_ms + step;
        default: now = report_time_m + cfg_model.report_interval_ms + step;
      endcase
      if (r >= 30 && r < 35) begin
        now = $urandom;
      end else if (r >= 35) begin
        if ($urandom_range(3) == 0) now = clock_ms;
        else now = clock_ms + $urandom_range(1, ($urandom_range(3) == 0) ? 100000 : 3000);
      end
      clock_ms = now;

      // Motion sample around the threshold, anywhere, or still.
      r = $urandom_range(99);
      if (r < 50) begin
        v = int'(cfg_model.motion_threshold) + int'($urandom_range(2)) - 1;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        accel = AccelW'(v);
      end else if (r < 80) begin
        accel = AccelW'($urandom);
      end else begin
        accel = '0;
      end

      // Battery code near the zero code, anywhere, or at an end of the range.
      r = $urandom_range(99);
      if (r < 40) begin
        v = int'(cfg_model.battery_zero_code) + int'($urandom_range(202)) - 2;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        adc = AdcW'(v);
      end else if (r < 80) begin
        adc = AdcW'($urandom);
      end else begin
        adc = $urandom_range(1) ? '1 : '0;
      end

      send_item(k, now, accel, adc);
      if (k != KIND_UNUSED) sent++;
      if (pause_every > 0 && sent % pause_every == 0 && k != KIND_UNUSED) begin
        // The sender holds off until every decision has come back.
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (expected_decisions.size() != 0);
      end
    end
    drain_decisions();
  endtask

  task automatic test_random_traffic();
    restore_defaults();
    run_traffic(250, 0);
    // A stretch without idling on either side.
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    randomise_registers();
    run_traffic(200, 0);
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    randomise_registers();
    run_traffic(250, 60);
    randomise_registers();
    run_traffic(250, 0);
    randomise_registers();
    run_traffic(200, 45);
  endtask

  // Result side: compare each accepted item with the oldest prediction, then pick the stall.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_decisions.size() == 0) begin
        flag_mismatch("unexpected result item, tdata", '0, 32'(m_axis_tdata));
      end else begin
        oldest = expected_decisions.pop_front();
        if (m_axis_tdata[1:0] !== oldest.state)
          flag_mismatch("device_state", 32'(oldest.state), 32'(m_axis_tdata[1:0]));
        if (m_axis_tdata[2] !== oldest.ranging)
          flag_mismatch("ranging_active", 32'(oldest.ranging), 32'(m_axis_tdata[2]));
        if (m_axis_tdata[3] !== oldest.pulse)
          flag_mismatch("battery_report", 32'(oldest.pulse), 32'(m_axis_tdata[3]));
        if (m_axis_tdata[10:4] !== oldest.percent)
          flag_mismatch("battery_percent", 32'(oldest.percent), 32'(m_axis_tdata[10:4]));
      end
    end
    if (!rx_stalls_on) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if ($urandom_range(99) < 70) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= 1'b0;
      stall_left    <= gap_length() - 1;
    end
  end

  // Watchdog: too long without any accepted item or register access ends the run.
  initial begin
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // Test sequence.
  initial begin
    reset_model();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_link_events();
    test_register_extremes();
    test_battery_percent();
    test_random_traffic();
    drain_decisions();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lpsm_pkg.sv
rtl/lpsm_regs.sv
rtl/link_power_state_manager.sv
test/link_power_state_manager_tb.sv
